@@ rtl/mtx3inv_pkg.sv @@
// ----------------------------------------------------------------------------
// mtx3inv_pkg
// Shared widths and types for the 3x3 adjugate / inverse block.
// ----------------------------------------------------------------------------
package mtx3inv_pkg;

	localparam int ELEM_W = 16;  // Q8.8 input element
	localparam int ADJ_W  = 33;  // Q16.16 cofactor / result element
	localparam int DET_W  = 52;  // internal determinant, never clips
	localparam int DETO_W = 50;  // determinant as delivered, Q24.24
	localparam int QUO_W  = 32;  // quotient bits produced by the divider
	localparam int NLANE  = 9;   // matrix elements
	localparam int FRONT_STAGES = 4;
	localparam int QUEUE_DEPTH  = 8;

	localparam int IN_TDATA_W  = 144;
	localparam int OUT_TDATA_W = 352;
	localparam int OUT_TUSER_W = 2;

	// tuser bit positions on the result channel
	localparam int TU_SINGULAR  = 0;
	localparam int TU_SATURATED = 1;

	localparam logic MODE_ADJ = 1'b0;
	localparam logic MODE_INV = 1'b1;

	// one classified matrix, front to back
	typedef struct packed {
		logic [NLANE-1:0][ADJ_W-1:0] adj;
		logic [DET_W-1:0]            det;
	} mtx_item_t;

endpackage

@@ rtl/matrix3_inverse_adjugate.sv @@
// ----------------------------------------------------------------------------
// matrix3_inverse_adjugate
// 3x3 Q8.8 matrix adjugate or fixed-point inverse with exact determinant.
// ----------------------------------------------------------------------------
// Input beats on s_axis carry one whole matrix (m00..m22, 16 bits each).
// Each input beat yields exactly one output beat on m_axis: nine Q16.16
// result elements, the exact Q24.24 determinant, and singular/saturated
// flags in tuser. cfg_we/cfg_wdata set mode (0 adjugate, 1 inverse);
// write it only while the block is empty.
// Throughput is one matrix per cycle while m_axis_tready stays high.
// From input beat to output beat a matrix passes four cofactor
// stages, the queue, the divider seed stage, 32 divider stages
// (one quotient bit each) and the output register.
// When the receiver stalls, the divider pipeline holds; the eight-entry
// queue absorbs matrices still in the cofactor stages, and s_axis_tready
// drops once queue entries plus matrices in flight reach its depth.
// Reset empties every stage and the queue and sets mode to inverse.
// ----------------------------------------------------------------------------
module matrix3_inverse_adjugate import mtx3inv_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // m00,m01,m02,m10,m11,m12,m20,m21,m22
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // r00..r22, determinant, zero pad
	output logic [OUT_TUSER_W-1:0] m_axis_tuser,  // singular, saturated
	input  logic                   cfg_we,
	input  logic                   cfg_wdata
);

	localparam int CW = $clog2(QDEPTH+1);

	logic      mode_q;
	logic      push, pop, q_ne;
	mtx_item_t push_item, q_head;
	logic [2:0]    inflight;
	logic [CW-1:0] q_count;
	logic [CW+2:0] occ;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_INV;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// credit: queue entries plus matrices still in the front
	assign occ = (CW+3)'(q_count) + (CW+3)'(inflight);
	assign s_axis_tready = occ < (CW+3)'(QDEPTH);

	mtx3inv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid && s_axis_tready),
		.in_data   (s_axis_tdata),
		.push      (push),
		.push_item (push_item),
		.inflight  (inflight)
	);

	mtx3inv_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (q_head),
		.not_empty (q_ne),
		.count     (q_count)
	);

	mtx3inv_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.mode        (mode_q),
		.q_not_empty (q_ne),
		.q_head      (q_head),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_data    (m_axis_tdata),
		.out_user    (m_axis_tuser)
	);

endmodule

@@ rtl/mtx3inv_front.sv @@
// ----------------------------------------------------------------------------
// mtx3inv_front
// Cofactor and determinant pipeline: four register stages, one matrix a beat.
// ----------------------------------------------------------------------------
module mtx3inv_front import mtx3inv_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [IN_TDATA_W-1:0] in_data,
	output logic                  push,
	output mtx_item_t             push_item,
	output logic [2:0]            inflight
);

	logic [FRONT_STAGES-1:0] vld_q;
	logic signed [ELEM_W-1:0] m_s1 [NLANE];
	logic signed [31:0] pa_s2 [NLANE];
	logic signed [31:0] pb_s2 [NLANE];
	logic signed [ELEM_W-1:0] col_s2 [3];
	logic signed [ELEM_W-1:0] col_s3 [3];
	logic signed [ADJ_W-1:0] adj_s3 [NLANE];
	logic signed [ADJ_W-1:0] adj_s4 [NLANE];
	logic signed [48:0] t_s4 [3];
	logic signed [DET_W-1:0] det_sum;

	// valid shift line, the front never stalls (queue credit guards it)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[FRONT_STAGES-2:0], in_valid};
		end
	end

	genvar k;
	generate
		for (k = 0; k < NLANE; k++) begin : g_lane
			localparam int SR = k / 3;
			localparam int SC = k % 3;
			localparam int R0 = (SR == 0) ? 1 : 0;
			localparam int R1 = (SR == 2) ? 1 : 2;
			localparam int C0 = (SC == 0) ? 1 : 0;
			localparam int C1 = (SC == 2) ? 1 : 2;
			// adj[r][c] comes from the minor that drops row c, column r
			localparam int AR = k / 3;
			localparam int AC = k % 3;
			localparam int MK = AC * 3 + AR;
			localparam bit NEG = ((AR + AC) % 2) == 1;

			// stage 1: capture element
			always_ff @(posedge clk) begin
				m_s1[k] <= $signed(in_data[k*ELEM_W +: ELEM_W]);
			end

			// stage 2: the two products of each 2x2 minor
			always_ff @(posedge clk) begin
				pa_s2[k] <= m_s1[R0*3+C0] * m_s1[R1*3+C1];
				pb_s2[k] <= m_s1[R0*3+C1] * m_s1[R1*3+C0];
			end

			// stage 3: signed cofactor, already transposed
			always_ff @(posedge clk) begin
				if (NEG) begin
					adj_s3[k] <= {pb_s2[MK][31], pb_s2[MK]} - {pa_s2[MK][31], pa_s2[MK]};
				end else begin
					adj_s3[k] <= {pa_s2[MK][31], pa_s2[MK]} - {pb_s2[MK][31], pb_s2[MK]};
				end
				adj_s4[k] <= adj_s3[k];
			end

			assign push_item.adj[k] = adj_s4[k];
		end

		for (k = 0; k < 3; k++) begin : g_col
			// column 0 travels along for the expansion
			always_ff @(posedge clk) begin
				col_s2[k] <= m_s1[k*3];
				col_s3[k] <= col_s2[k];
				// det = a00*adj00 + a10*adj01 + a20*adj02
				t_s4[k]   <= col_s3[k] * adj_s3[k];
			end
		end
	endgenerate

	// expansion sum feeds the queue directly
	assign det_sum = DET_W'(t_s4[0]) + DET_W'(t_s4[1]) + DET_W'(t_s4[2]);
	assign push_item.det = det_sum;
	assign push = vld_q[FRONT_STAGES-1];
	assign inflight = 3'($countones(vld_q));

endmodule

@@ rtl/mtx3inv_queue.sv @@
// ----------------------------------------------------------------------------
// mtx3inv_queue
// Small FIFO between the cofactor front and the divider back.
// ----------------------------------------------------------------------------
module mtx3inv_queue import mtx3inv_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  mtx_item_t                    push_item,
	input  logic                         pop,
	output mtx_item_t                    head,
	output logic                         not_empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	mtx_item_t       mem [DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;

	// storage write
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_item;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign head      = mem[rd_q];
	assign not_empty = (cnt_q != '0);
	assign count     = cnt_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> cnt_q < CW'(DEPTH))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("queue read while empty");

endmodule

@@ rtl/mtx3inv_back.sv @@
// ----------------------------------------------------------------------------
// mtx3inv_back
// Nine-lane restoring divider, one quotient bit per stage, plus result stage.
// ----------------------------------------------------------------------------
module mtx3inv_back import mtx3inv_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   mode,
	input  logic                   q_not_empty,
	input  mtx_item_t              q_head,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_TDATA_W-1:0] out_data,
	output logic [OUT_TUSER_W-1:0] out_user
);

	localparam int NST = QUO_W + 1;

	typedef struct packed {
		logic [DET_W-1:0]  rem;
		logic [QUO_W-1:0] nq;   // numerator low bits in, quotient bits out
		logic              ovf;
		logic              neg;
		logic [ADJ_W-1:0]  adj;
	} lane_t;

	typedef struct packed {
		logic [DET_W-1:0] dmag;
		logic [DET_W-1:0] det;
	} com_t;

	logic              en;
	logic [NST-1:0]    vld_s;
	lane_t             lane_s [NST][NLANE];
	com_t              com_s  [NST];
	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic [OUT_TUSER_W-1:0] out_user_q;
	logic [NLANE-1:0][ADJ_W-1:0] res;
	logic [NLANE-1:0]            sat_l;
	logic                        sing;
	logic [DET_W-1:0]            hd_dmag;

	// whole back advances when the result register is free
	assign en  = !out_valid_q || out_ready;
	assign pop = en && q_not_empty;
	assign hd_dmag = q_head.det[DET_W-1] ? DET_W'(-$signed(q_head.det)) : q_head.det;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NST-2:0], pop};
		end
	end

	// stage 0: magnitudes, overflow precheck, remainder seed
	always_ff @(posedge clk) begin
		if (en) begin
			com_s[0].dmag <= hd_dmag;
			com_s[0].det  <= q_head.det;
		end
	end

	genvar l, s;
	generate
		for (l = 0; l < NLANE; l++) begin : g_seed
			logic [ADJ_W-1:0] amag;
			assign amag = q_head.adj[l][ADJ_W-1] ? ADJ_W'(-$signed(q_head.adj[l]))
			                                     : q_head.adj[l];
			always_ff @(posedge clk) begin
				if (en) begin
					lane_s[0][l].rem <= DET_W'(amag[ADJ_W-1:8]);
					lane_s[0][l].nq  <= {amag[7:0], 24'd0};
					lane_s[0][l].ovf <= DET_W'(amag[ADJ_W-1:8]) >= hd_dmag;
					lane_s[0][l].neg <= q_head.adj[l][ADJ_W-1] ^ q_head.det[DET_W-1];
					lane_s[0][l].adj <= q_head.adj[l];
				end
			end
		end

		// one quotient bit per stage
		for (s = 0; s < QUO_W; s++) begin : g_stage
			always_ff @(posedge clk) begin
				if (en) begin
					com_s[s+1] <= com_s[s];
				end
			end
			for (l = 0; l < NLANE; l++) begin : g_div
				logic [DET_W:0] trial;
				logic           ge;
				assign trial = {lane_s[s][l].rem, lane_s[s][l].nq[QUO_W-1]};
				assign ge    = trial >= {1'b0, com_s[s].dmag};
				always_ff @(posedge clk) begin
					if (en) begin
						lane_s[s+1][l].rem <= ge ? DET_W'(trial - {1'b0, com_s[s].dmag})
						                         : trial[DET_W-1:0];
						lane_s[s+1][l].nq  <= {lane_s[s][l].nq[QUO_W-2:0], ge};
						lane_s[s+1][l].ovf <= lane_s[s][l].ovf;
						lane_s[s+1][l].neg <= lane_s[s][l].neg;
						lane_s[s+1][l].adj <= lane_s[s][l].adj;
					end
				end
			end
		end

		// result per lane: adjugate in adjugate mode, zero when singular, else saturation and sign
		for (l = 0; l < NLANE; l++) begin : g_res
			logic [QUO_W-1:0] q;
			logic             ovf, nz, ng;
			assign q   = lane_s[NST-1][l].nq;
			assign ovf = lane_s[NST-1][l].ovf;
			assign nz  = ovf || (q != '0);
			assign ng  = lane_s[NST-1][l].neg && nz;
			always_comb begin
				sat_l[l] = 1'b0;
				res[l]   = '0;
				if (mode == MODE_ADJ) begin
					res[l] = lane_s[NST-1][l].adj;
				end else if (!sing) begin
					if (ng) begin
						if (ovf || (q[QUO_W-1] && q[QUO_W-2:0] != '0)) begin
							sat_l[l] = 1'b1;
							res[l]   = {1'b1, 1'b1, {(QUO_W-1){1'b0}}};
						end else begin
							res[l] = ADJ_W'(-$signed({1'b0, q}));
						end
					end else if (ovf || q[QUO_W-1]) begin
						sat_l[l] = 1'b1;
						res[l]   = {2'b00, {(QUO_W-1){1'b1}}};
					end else begin
						res[l] = {1'b0, q};
					end
				end
			end
		end
	endgenerate

	assign sing = (com_s[NST-1].det == '0);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_s[NST-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= {5'd0, com_s[NST-1].det[DETO_W-1:0], res};
			out_user_q[TU_SINGULAR]  <= sing;
			out_user_q[TU_SATURATED] <= |sat_l;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_user  = out_user_q;

	a_sat_not_sing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_user_q[TU_SATURATED] && out_user_q[TU_SINGULAR]))
		else $error("saturation reported on a singular matrix");
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_user_q[TU_SINGULAR] && mode == MODE_INV
		|-> out_data_q[NLANE*ADJ_W-1:0] == '0)
		else $error("singular inverse not zero");
	a_adj_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && mode == MODE_ADJ |-> !out_user_q[TU_SATURATED])
		else $error("saturation in adjugate mode");

endmodule

@@ verif/matrix3_inverse_adjugate_tb.sv @@
// ----------------------------------------------------------------------------
// matrix3_inverse_adjugate_tb
// Self-checking bench for the 3x3 adjugate / inverse block.
// ----------------------------------------------------------------------------
// Each matrix beat is predicted in the bench (cofactors, determinant, and
// in inverse mode a truncating, saturating divide), queued, and compared
// field by field with the beats that come out. Mode is switched only while
// the block is drained. Random idle bursts fall on both sides, except in
// the closing stretch.
// ----------------------------------------------------------------------------
module matrix3_inverse_adjugate_tb;
	import mtx3inv_pkg::*;

	typedef struct {
		logic signed [ADJ_W-1:0] elem [9];
		logic signed [DETO_W-1:0] det;
		logic sing;
		logic sat;
	} inv_result_t;

	// prediction store and checker
	class inverse_scoreboard;
		inv_result_t pending[$];
		logic mode_r;
		int errors;

		function new();
			mode_r = MODE_INV;
			errors = 0;
		endfunction

		// |a| * 2^24 / |d|, truncated toward zero, clipped to 32 bits signed
		function automatic longint quotient(longint a, longint d, inout logic sat);
			longint ua, ud, q;
			logic neg;
			ua = (a < 0) ? -a : a;
			ud = (d < 0) ? -d : d;
			q = (ua <<< 24) / ud;
			neg = ((a < 0) != (d < 0)) && (q != 0);
			if (neg) begin
				if (q > 64'sd2147483648) begin
					q = 64'sd2147483648;
					sat = 1'b1;
				end
				return -q;
			end
			if (q > 64'sd2147483647) begin
				q = 64'sd2147483647;
				sat = 1'b1;
			end
			return q;
		endfunction

		function automatic void note_matrix(logic [IN_TDATA_W-1:0] data);
			longint a [3][3];
			longint adj [3][3];
			longint mn, det;
			int r0, r1, c0, c1;
			inv_result_t res;
			res.sat = 1'b0;
			for (int i = 0; i < 9; i++)
				a[i/3][i%3] = longint'($signed(data[i*ELEM_W +: ELEM_W]));
			// adj[r][c] = (-1)^(r+c) * minor with row c and column r removed
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++) begin
					r0 = (c == 0) ? 1 : 0;
					r1 = (c == 2) ? 1 : 2;
					c0 = (r == 0) ? 1 : 0;
					c1 = (r == 2) ? 1 : 2;
					mn = a[r0][c0] * a[r1][c1] - a[r0][c1] * a[r1][c0];
					adj[r][c] = ((r + c) % 2) ? -mn : mn;
				end
			// expansion along column 0 equals row 0 of adj against column 0
			det = a[0][0] * adj[0][0] + a[1][0] * adj[0][1] + a[2][0] * adj[0][2];
			res.det = det[DETO_W-1:0];
			res.sing = (det == 0);
			for (int i = 0; i < 9; i++) begin
				longint v;
				if (mode_r == MODE_ADJ) v = adj[i/3][i%3];
				else if (res.sing) v = 0;
				else v = quotient(adj[i/3][i%3], det, res.sat);
				res.elem[i] = v[ADJ_W-1:0];
			end
			pending.push_back(res);
		endfunction

		function automatic void check_beat(logic [OUT_TDATA_W-1:0] data,
				logic [OUT_TUSER_W-1:0] user);
			inv_result_t exp_r;
			logic bad;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result beat: %h", data);
				return;
			end
			exp_r = pending.pop_front();
			bad = (data[9*ADJ_W +: DETO_W] !== exp_r.det)
				|| (user[TU_SINGULAR] !== exp_r.sing)
				|| (user[TU_SATURATED] !== exp_r.sat);
			for (int i = 0; i < 9; i++)
				if (data[i*ADJ_W +: ADJ_W] !== exp_r.elem[i]) bad = 1'b1;
			if (bad) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch: det exp %h got %h, sing exp %b got %b, sat exp %b got %b",
						exp_r.det, data[9*ADJ_W +: DETO_W], exp_r.sing,
						user[TU_SINGULAR], exp_r.sat, user[TU_SATURATED]);
					for (int i = 0; i < 9; i++)
						$display("  r%0d%0d exp %h got %h", i/3, i%3, exp_r.elem[i],
							data[i*ADJ_W +: ADJ_W]);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;   // m00,m01,m02,m10,m11,m12,m20,m21,m22
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;       // r00..r22, determinant, zero pad
	logic [OUT_TUSER_W-1:0] m_axis_tuser;       // singular, saturated
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;

	inverse_scoreboard sb = new();
	logic quiet = 1'b0;
	int cycles = 0;
	int rx_idle = 0;

	matrix3_inverse_adjugate i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// receiver: random stall bursts, check each accepted beat
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_beat(m_axis_tdata, m_axis_tuser);
		if (rx_idle > 0) begin
			rx_idle <= rx_idle - 1;
			m_axis_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			rx_idle <= $urandom_range(1, 7) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic send_matrix(logic [IN_TDATA_W-1:0] data);
		int gap;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 7);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= data;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_matrix(data);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (45) @(posedge clk);
	endtask

	task automatic set_mode(logic m);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.mode_r = m;
	endtask

	function automatic logic [ELEM_W-1:0] rand_elem();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($signed($urandom_range(0, 1024)) - 512);
			3: return 16'($signed($urandom_range(0, 64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [IN_TDATA_W-1:0] rand_matrix();
		logic [IN_TDATA_W-1:0] d;
		int kind;
		kind = $urandom_range(0, 9);
		for (int i = 0; i < 9; i++) d[i*ELEM_W +: ELEM_W] = rand_elem();
		// duplicated row gives a singular matrix
		if (kind == 0) d[3*ELEM_W +: 3*ELEM_W] = d[0 +: 3*ELEM_W];
		// tiny random elements: small determinant, large inverse
		if (kind == 1) begin
			d = '0;
			for (int i = 0; i < 9; i++)
				d[i*ELEM_W +: ELEM_W] = 16'($signed($urandom_range(0, 6)) - 3);
		end
		return d;
	endfunction

	function automatic logic [IN_TDATA_W-1:0] fill(logic [ELEM_W-1:0] v);
		logic [IN_TDATA_W-1:0] d;
		for (int i = 0; i < 9; i++) d[i*ELEM_W +: ELEM_W] = v;
		return d;
	endfunction

	function automatic logic [IN_TDATA_W-1:0] diag(logic [ELEM_W-1:0] v);
		logic [IN_TDATA_W-1:0] d;
		d = '0;
		d[0 +: ELEM_W] = v;
		d[4*ELEM_W +: ELEM_W] = v;
		d[8*ELEM_W +: ELEM_W] = v;
		return d;
	endfunction

	task automatic directed_set();
		send_matrix('0);                    // all zero, singular
		send_matrix(fill(16'hffff));        // all ones bits, singular
		send_matrix(diag(16'h0100));        // identity
		send_matrix(diag(16'h0001));        // tiny determinant, large inverse
		send_matrix(diag(16'h8000));        // most negative elements
		send_matrix(diag(16'h7fff));
		send_matrix(diag(16'hff00));        // minus identity
		send_matrix({16'h0100, 16'h0000, 16'h8000, 16'h0000, 16'h7fff,
			16'h0000, 16'h8000, 16'h0000, 16'h0200});
		send_matrix({9{16'h5555}} ^ {16'h0000, {8{16'hffff}}});
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// reset mode is inverse
		directed_set();
		drain();
		set_mode(MODE_ADJ);
		directed_set();
		drain();
		set_mode(MODE_INV);
		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 5) quiet = 1'b1;
			for (int n = 0; n < 320; n++) send_matrix(rand_matrix());
			drain();
			set_mode(phase % 2 ? MODE_INV : MODE_ADJ);
		end
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
